// ===== design/iate_pkg.sv =====
package iate_pkg;

   // Sizes fixed by the beat formats.
   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam int unsigned DATA_W        = 32;
   localparam int unsigned INDEX_W       = 8;
   localparam int unsigned CMD_W         = 3;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned SLOT_W        = 7;
   localparam int unsigned TOTAL_W       = 38;

   // Capacity after reset.
   localparam logic [SLOT_W-1:0] CAPACITY_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_SEARCH = 3'd2,
      CMD_GET    = 3'd3,
      CMD_SET    = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Broadcast from the controller to every cell of the row.
   typedef struct packed {
      cmd_type              command;
      logic [INDEX_W-1:0]   index;
      logic [DATA_W-1:0]    value;
      logic [DATA_W-1:0]    key;
      logic                 commit;
   } cell_ctrl_type;

endpackage

// ===== design/iate_if.sv =====
interface iate_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [iate_pkg::CMD_W-1:0]            command;
   logic [iate_pkg::INDEX_W-1:0]          index;
   logic signed [iate_pkg::DATA_W-1:0]    value;
   logic signed [iate_pkg::DATA_W-1:0]    key;

   modport source (output valid, command, index, value, key, input ready);
   modport sink   (input valid, command, index, value, key, output ready);
endinterface

interface iate_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [iate_pkg::STATUS_W-1:0]         status;
   logic signed [iate_pkg::SLOT_W-1:0]    found_index;
   logic signed [iate_pkg::DATA_W-1:0]    read_value;
   logic [iate_pkg::SLOT_W-1:0]           entry_count;
   logic signed [iate_pkg::TOTAL_W-1:0]   total;

   modport source (output valid, status, found_index, read_value, entry_count, total,
                   input ready);
   modport sink   (input valid, status, found_index, read_value, entry_count, total,
                   output ready);
endinterface

// ===== design/iate_cell.sv =====
module iate_cell #(
   parameter int unsigned POS = 0
) (
   input  logic                          clock,
   input  iate_pkg::cell_ctrl_type       ctrl,
   input  logic                          in_use,
   input  logic [iate_pkg::DATA_W-1:0]   left_data,
   input  logic [iate_pkg::DATA_W-1:0]   right_data,
   output logic [iate_pkg::DATA_W-1:0]   data,
   output logic                          match,
   output logic                          hit
);
   import iate_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              at_index;
   logic              above_index;

   // Position of this cell relative to the commanded index.
   assign at_index    = (32'(ctrl.index) == POS);
   assign above_index = (32'(ctrl.index) < POS);

   // Insert pulls from the lower neighbour, delete from the upper one.
   always_comb begin
      data_in = data_ff;
      if (ctrl.commit) begin
         unique case (ctrl.command)
            CMD_INSERT: begin
               if (above_index) begin
                  data_in = left_data;
               end else if (at_index) begin
                  data_in = ctrl.value;
               end
            end
            CMD_DELETE: begin
               if (above_index || at_index) begin
                  data_in = right_data;
               end
            end
            CMD_SET: begin
               if (at_index) begin
                  data_in = ctrl.value;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Only entries below the fill count take part in a search.
   assign data  = data_ff;
   assign match = in_use && (data_ff == ctrl.key);
   assign hit   = at_index;

endmodule

// ===== design/indexed_array_table_engine.sv =====
// Indexed array table engine: a packed array of signed 32-bit entries held in a
// row of cells, one entry per cell.
// req_chan carries one command per beat (insert, delete, search, get, set) with
// its index, value and key; rsp_chan returns exactly one result beat per
// command with status, found index, read value, entry count and running total.
// csr_wr_en/csr_wr_data load the capacity register; write it only while idle.
// Each command beat is registered on acceptance, and in the execute state every
// cell compares or shifts at once while the result is formed and loaded into
// the output register. The one-entry controller takes a new request only in the
// idle state that follows the finish of the previous command.
// A request is accepted while the previous result still waits in the output
// register; if the receiver stalls, the following command is held in its
// execute cycle until the output register is free.
// Reset clears the entry count, the total and the output valid flag and sets
// the capacity to 64; entry contents are not cleared and need no clearing pass.
module indexed_array_table_engine #(
   parameter int unsigned DEPTH = iate_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   iate_req_if.sink                      req_chan,
   iate_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [iate_pkg::SLOT_W-1:0]   csr_wr_data
);
   import iate_pkg::*;

   localparam int unsigned POS_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type              state_ff, state_in;
   logic [SLOT_W-1:0]      capacity_ff, capacity_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   cmd_type                cmd_ff;
   logic [INDEX_W-1:0]     index_ff;
   logic [DATA_W-1:0]      value_ff;
   logic [DATA_W-1:0]      key_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [SLOT_W-1:0]      rsp_found_ff;
   logic [DATA_W-1:0]      rsp_read_ff;
   logic [SLOT_W-1:0]      rsp_count_ff;
   logic [TOTAL_W-1:0]     rsp_total_ff;

   cell_ctrl_type          ctrl;
   logic [DEPTH-1:0]       match_vec;
   logic [DEPTH-1:0]       hit_vec;
   logic [DEPTH-1:0]       in_use_vec;
   logic [DEPTH-1:0]       first_vec;
   logic [DATA_W-1:0]      cell_data [DEPTH];
   logic [POS_W-1:0]       found_pos;
   logic [DATA_W-1:0]      sel_data;

   logic                   slot_free;
   logic                   finish;
   status_type             status;
   logic [31:0]            index_wide;
   logic [31:0]            count_wide;
   logic [31:0]            limit_wide;
   logic [TOTAL_W-1:0]     value_ext;
   logic [TOTAL_W-1:0]     sel_ext;
   logic [TOTAL_W-1:0]     add_term;
   logic [TOTAL_W-1:0]     sub_term;
   logic [SLOT_W-1:0]      found_out;
   logic [DATA_W-1:0]      read_out;

   // Broadcast of the registered command to the row of cells.
   assign ctrl.command = cmd_ff;
   assign ctrl.index   = index_ff;
   assign ctrl.value   = value_ff;
   assign ctrl.key     = key_ff;

   // Row of cells; each one hands its entry to both neighbours.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = value_ff;
      end else begin : g_mid_lo
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_mid_hi
         assign right_data = cell_data[i+1];
      end

      assign in_use_vec[i] = (32'(count_ff) > i);

      iate_cell #(
         .POS (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .in_use     (in_use_vec[i]),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .match      (match_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   // Lowest matching cell isolated as a one-hot word, then encoded.
   assign first_vec = match_vec & (~match_vec + DEPTH'(1));

   always_comb begin
      found_pos = '0;
      sel_data  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         found_pos = found_pos | (first_vec[i] ? POS_W'(i) : POS_W'(0));
         sel_data  = sel_data | (hit_vec[i] ? cell_data[i] : '0);
      end
   end

   // Range and capacity checks against the current fill count.
   assign index_wide = 32'(index_ff);
   assign count_wide = 32'(count_ff);
   assign limit_wide = (32'(capacity_ff) > DEPTH) ? DEPTH : 32'(capacity_ff);

   always_comb begin
      status = STATUS_DONE;
      unique case (cmd_ff)
         CMD_INSERT: begin
            priority if (index_wide > count_wide) begin
               status = STATUS_RANGE;
            end else if (count_wide >= limit_wide) begin
               status = STATUS_FULL;
            end else begin
               status = STATUS_DONE;
            end
         end
         CMD_DELETE, CMD_GET, CMD_SET: begin
            if (index_wide >= count_wide) begin
               status = STATUS_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   // The execute cycle completes once the output register can take the result.
   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;
   assign finish      = (state_ff == ST_EXEC) && slot_free;
   assign ctrl.commit = finish && (status == STATUS_DONE) &&
                        (cmd_ff == CMD_INSERT || cmd_ff == CMD_DELETE || cmd_ff == CMD_SET);

   // Count, total and result fields after the command.
   assign value_ext = {{(TOTAL_W-DATA_W){value_ff[DATA_W-1]}}, value_ff};
   assign sel_ext   = {{(TOTAL_W-DATA_W){sel_data[DATA_W-1]}}, sel_data};

   always_comb begin
      count_in  = count_ff;
      add_term  = '0;
      sub_term  = '0;
      found_out = '1;
      read_out  = '0;
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (status == STATUS_DONE) begin
               count_in = count_ff + COUNT_W'(1);
               add_term = value_ext;
            end
         end
         CMD_DELETE: begin
            if (status == STATUS_DONE) begin
               count_in = count_ff - COUNT_W'(1);
               sub_term = sel_ext;
               read_out = sel_data;
            end
         end
         CMD_SEARCH: begin
            if (|match_vec) begin
               found_out = SLOT_W'(found_pos);
            end
         end
         CMD_GET: begin
            read_out = (status == STATUS_DONE) ? sel_data : '1;
         end
         CMD_SET: begin
            if (status == STATUS_DONE) begin
               add_term = value_ext;
               sub_term = sel_ext;
            end
         end
         default: begin
         end
      endcase
      total_in = total_ff + add_term - sub_term;
   end

   // Controller next state and output register handshake.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

   // State, registered request and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         total_ff     <= '0;
         capacity_ff  <= CAPACITY_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         capacity_ff  <= capacity_in;
         if (finish) begin
            count_ff      <= count_in;
            total_ff      <= total_in;
            rsp_status_ff <= status;
            rsp_found_ff  <= found_out;
            rsp_read_ff   <= read_out;
            rsp_count_ff  <= SLOT_W'(count_in);
            rsp_total_ff  <= total_in;
         end
         if (req_chan.valid && req_chan.ready) begin
            cmd_ff   <= cmd_type'(req_chan.command);
            index_ff <= req_chan.index;
            value_ff <= req_chan.value;
            key_ff   <= req_chan.key;
         end
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_index = rsp_found_ff;
   assign rsp_chan.read_value  = rsp_read_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.total       = rsp_total_ff;

   // The fill count never passes the number of cells.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("entry count beyond the number of cells");

   // An accepted request beat always moves the controller into execute.
   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not start execution");

   // A finished command always leaves a result in the output register.
   a_finish_rsp : assert property (@(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff)
      else $error("finished command left no result");

   // Cells are never updated outside a finishing execute cycle.
   a_commit_exec : assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |-> (state_ff == ST_EXEC && slot_free))
      else $error("cell row updated outside execution");

endmodule

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import iate_pkg::*;

   // One result beat as the block should produce it.
   typedef struct {
      status_type                 status;
      logic signed [SLOT_W-1:0]   found_index;
      logic signed [DATA_W-1:0]   read_value;
      logic [SLOT_W-1:0]          entry_count;
      logic signed [TOTAL_W-1:0]  total;
   } table_result_type;

   // Mirror of the packed array: applies each accepted command to its own copy of the
   // entries and queues the result beat that the command must produce.
   class array_mirror_type;
      logic signed [DATA_W-1:0] entries [DEPTH_DEFAULT];
      int unsigned              count;
      longint                   sum;
      int unsigned              capacity;
      int unsigned              mismatches;
      table_result_type         expected_results [$];

      function new();
         foreach (entries[i]) entries[i] = '0;
         count      = 0;
         sum        = 0;
         capacity   = 32'(CAPACITY_RESET);
         mismatches = 0;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      function void note_command(logic [CMD_W-1:0] command, logic [INDEX_W-1:0] index,
                                 logic signed [DATA_W-1:0] value,
                                 logic signed [DATA_W-1:0] key);
         table_result_type r;
         int unsigned      limit;
         int unsigned      i;
         limit         = (capacity > DEPTH_DEFAULT) ? DEPTH_DEFAULT : capacity;
         r.status      = STATUS_DONE;
         r.found_index = '1;
         r.read_value  = '0;
         case (command)
            CMD_INSERT: begin
               // The index check takes precedence over the full check.
               if (index > count) begin
                  r.status = STATUS_RANGE;
               end else if (count >= limit) begin
                  r.status = STATUS_FULL;
               end else begin
                  for (i = count; i > index; i--) entries[i] = entries[i-1];
                  entries[index] = value;
                  count++;
                  sum = sum + longint'(value);
               end
            end
            CMD_DELETE: begin
               if (index >= count) begin
                  r.status = STATUS_RANGE;
               end else begin
                  r.read_value = entries[index];
                  for (i = index; i + 1 < count; i++) entries[i] = entries[i+1];
                  count--;
                  sum = sum - longint'(r.read_value);
               end
            end
            CMD_SEARCH: begin
               // The lowest matching position wins.
               for (i = 0; i < count; i++) begin
                  if (entries[i] == key) begin
                     r.found_index = SLOT_W'(i);
                     break;
                  end
               end
            end
            CMD_GET: begin
               if (index >= count) begin
                  r.status     = STATUS_RANGE;
                  r.read_value = -1;
               end else begin
                  r.read_value = entries[index];
               end
            end
            CMD_SET: begin
               if (index >= count) begin
                  r.status = STATUS_RANGE;
               end else begin
                  sum = sum + longint'(value) - longint'(entries[index]);
                  entries[index] = value;
               end
            end
            default: begin
               // Unused command codes leave the array alone.
            end
         endcase
         r.entry_count = SLOT_W'(count);
         r.total       = TOTAL_W'(sum);
         expected_results.push_back(r);
      endfunction

      task check_result(logic [STATUS_W-1:0] status, logic signed [SLOT_W-1:0] found_index,
                        logic signed [DATA_W-1:0] read_value, logic [SLOT_W-1:0] entry_count,
                        logic signed [TOTAL_W-1:0] total);
         table_result_type want;
         if (expected_results.size() == 0) begin
            report("result beat arrived with nothing outstanding");
            return;
         end
         want = expected_results.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, expected %0d", status, want.status));
         if (found_index !== want.found_index)
            report($sformatf("found_index %0d, expected %0d", found_index, want.found_index));
         if (read_value !== want.read_value)
            report($sformatf("read_value %0d, expected %0d", read_value, want.read_value));
         if (entry_count !== want.entry_count)
            report($sformatf("entry_count %0d, expected %0d", entry_count, want.entry_count));
         if (total !== want.total)
            report($sformatf("total %0d, expected %0d", total, want.total));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [SLOT_W-1:0] csr_wr_data;

   iate_req_if req_bus ();
   iate_rsp_if rsp_bus ();

   array_mirror_type mirror = new();

   // Set for the closing stretch, where neither side idles.
   bit          calm;
   // Bumped by the stimulus to ask the receiver for one long hold-off.
   int unsigned hold_requests;

   indexed_array_table_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Offer one command beat, after an occasional idle burst, and wait until it is taken.
   task automatic send_command(logic [CMD_W-1:0] command, logic [INDEX_W-1:0] index,
                               logic signed [DATA_W-1:0] value,
                               logic signed [DATA_W-1:0] key);
      int unsigned gap;
      gap = 0;
      if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= command;
      req_bus.index   <= index;
      req_bus.value   <= value;
      req_bus.key     <= key;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      mirror.note_command(command, index, value, key);
   endtask

   // Load the capacity once every outstanding result has come back.
   task automatic set_capacity(logic [SLOT_W-1:0] capacity);
      req_bus.valid <= 1'b0;
      while (mirror.expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= capacity;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror.capacity = 32'(capacity);
   endtask

   // Extremes and small numbers often, so that totals and matches stay interesting.
   function automatic logic signed [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return -32'sd1;
         3:       return '0;
         4, 5:    return $signed($urandom_range(0, 40)) - 20;
         default: return $urandom;
      endcase
   endfunction

   // A random command that mostly uses a sensible index, with some stray ones.
   task automatic send_random(int unsigned insert_bias);
      logic [CMD_W-1:0]         command;
      logic [INDEX_W-1:0]       index;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] key;
      int unsigned              pick;
      pick = $urandom_range(0, 99);
      if (pick < insert_bias)
         command = CMD_INSERT;
      else if (pick >= 97)
         command = CMD_W'($urandom_range(5, 7));
      else
         command = CMD_W'($urandom_range(CMD_DELETE, CMD_SET));
      if ($urandom_range(0, 9) == 0)
         index = INDEX_W'($urandom_range(0, 255));
      else
         index = INDEX_W'($urandom_range(0, mirror.count));
      value = pick_word();
      if (mirror.count != 0 && $urandom_range(0, 9) < 6)
         key = mirror.entries[$urandom_range(0, mirror.count - 1)];
      else
         key = pick_word();
      send_command(command, index, value, key);
   endtask

   task automatic run_phase(logic [SLOT_W-1:0] capacity, int unsigned items,
                            int unsigned insert_bias);
      set_capacity(capacity);
      repeat (items) send_random(insert_bias);
   endtask

   // Stimulus.
   initial begin
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.command <= '0;
      req_bus.index   <= '0;
      req_bus.value   <= '0;
      req_bus.key     <= '0;
      calm            = 1'b0;
      hold_requests   = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty array: every indexed command is out of range and nothing is found.
      send_command(CMD_SEARCH, 8'd0, 32'sd0, 32'sd0);
      send_command(CMD_GET, 8'd0, 32'sd0, 32'sd0);
      send_command(CMD_DELETE, 8'd0, 32'sd0, 32'sd0);
      send_command(CMD_SET, 8'd0, 32'sd1, 32'sd0);
      send_command(CMD_INSERT, 8'd1, 32'sd1, 32'sd0);
      // Build up with the extreme values, a duplicate among them.
      send_command(CMD_INSERT, 8'd0, 32'sh7FFF_FFFF, 32'sd0);
      send_command(CMD_INSERT, 8'd0, 32'sh8000_0000, 32'sd0);
      send_command(CMD_INSERT, 8'd2, -32'sd1, 32'sd0);
      send_command(CMD_INSERT, 8'd1, 32'sd0, 32'sd0);
      send_command(CMD_INSERT, 8'd1, 32'sd0, 32'sd0);
      send_command(CMD_SEARCH, 8'd0, 32'sd0, 32'sd0);
      send_command(CMD_SEARCH, 8'd0, 32'sd0, 32'sh8000_0000);
      send_command(CMD_SEARCH, 8'd0, 32'sd0, -32'sd1);
      send_command(CMD_SEARCH, 8'd0, 32'sd0, 32'sh1234_5678);
      send_command(CMD_GET, 8'd3, 32'sd0, 32'sd0);
      send_command(CMD_GET, 8'd5, 32'sd0, 32'sd0);
      send_command(CMD_GET, 8'd255, 32'sd0, 32'sd0);
      send_command(CMD_SET, 8'd4, 32'sh5555_5555, 32'sd0);
      send_command(CMD_SET, 8'd5, 32'sd7, 32'sd0);
      send_command(CMD_DELETE, 8'd0, 32'sd0, 32'sd0);
      send_command(CMD_DELETE, 8'd4, 32'sd0, 32'sd0);
      send_command(CMD_DELETE, 8'd3, 32'sd0, 32'sd0);
      send_command(CMD_W'(5), 8'd255, -32'sd1, -32'sd1);
      send_command(CMD_W'(6), 8'd255, -32'sd1, -32'sd1);
      send_command(CMD_W'(7), 8'd255, -32'sd1, -32'sd1);
      send_command(CMD_INSERT, 8'd255, 32'sd3, 32'sd0);

      // Capacity lowered below the count: inserts are full, a bad index is still range.
      set_capacity(7'd1);
      send_command(CMD_INSERT, 8'd0, 32'sd9, 32'sd0);
      send_command(CMD_INSERT, 8'd9, 32'sd9, 32'sd0);
      repeat (40) send_random(30);

      // Zero capacity, then beyond the array depth, filling it to the brim.
      run_phase(7'd0, 30, 20);
      run_phase(7'd127, 220, 70);

      // Full depth again, with one long hold-off on the result side mid-phase.
      run_phase(7'd64, 60, 35);
      hold_requests++;
      repeat (90) send_random(35);

      run_phase(7'd2, 60, 45);
      run_phase(SLOT_W'($urandom_range(1, 64)), 150, 40);

      // Closing stretch without idling on either side.
      calm = 1'b1;
      run_phase(7'd64, 150, 40);

      req_bus.valid <= 1'b0;
      while (mirror.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("[indexed_array_table_engine] OK");
      end else begin
         $display("[indexed_array_table_engine] ERROR");
      end
      $finish;
   end

   // Result side: check each accepted beat and drive ready with random stalls.
   initial begin
      int unsigned stall_left;
      int unsigned holds_seen;
      stall_left = 0;
      holds_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            mirror.check_result(rsp_bus.status, rsp_bus.found_index, rsp_bus.read_value,
                                rsp_bus.entry_count, rsp_bus.total);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            stall_left = 200;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9);
         end
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog.
   initial begin
      #2_000_000;
      $display("[indexed_array_table_engine] ERROR");
      $finish;
   end

endmodule
